// File: hw/rtl/nnsf_pkg.sv
// Shared types and constants for the nearest-neighbor frame scaler.
// Holds register widths, reset values, register codes and the control/status structs.
// No dependencies.
`timescale 1ns / 1ps

package nnsf_pkg;

	// default sizing of the block
	localparam int MAX_SRC_WIDTH_DEF  = 512;
	localparam int MAX_SRC_HEIGHT_DEF = 256;
	localparam int MAX_DST_DIM_DEF    = 4096;

	// fixed field widths
	localparam int PIXEL_W      = 8;
	localparam int SRC_WIDTH_W  = 10;
	localparam int SRC_HEIGHT_W = 9;
	localparam int DST_DIM_W    = 13;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 13;

	// register reset values
	localparam logic [SRC_WIDTH_W-1:0]  SRC_WIDTH_RST  = SRC_WIDTH_W'(320);
	localparam logic [SRC_HEIGHT_W-1:0] SRC_HEIGHT_RST = SRC_HEIGHT_W'(200);
	localparam logic [DST_DIM_W-1:0]    DST_WIDTH_RST  = DST_DIM_W'(640);
	localparam logic [DST_DIM_W-1:0]    DST_HEIGHT_RST = DST_DIM_W'(400);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SRC_WIDTH  = 3'd0,
		REG_SRC_HEIGHT = 3'd1,
		REG_DST_WIDTH  = 3'd2,
		REG_DST_HEIGHT = 3'd3,
		REG_FLIP_X     = 3'd4,
		REG_FLIP_Y     = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [SRC_WIDTH_W-1:0]  src_width;
		logic [SRC_HEIGHT_W-1:0] src_height;
		logic [DST_DIM_W-1:0]    dst_width;
		logic [DST_DIM_W-1:0]    dst_height;
		logic                    flip_x;
		logic                    flip_y;
	} cfg_t;

	// controller to datapath
	typedef struct packed {
		logic capture;     // take the input word
		logic load;        // write the store and advance the load pointer
		logic map;         // map counters to source position, start accumulator sum
		logic addr;        // read the store, quick quotient check
		logic apply_fast;  // commit counters with the quick quotient
		logic div_start;   // load the long divider
		logic div_step;    // one quotient bit
		logic apply_div;   // commit counters with the long quotient
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic need_div;
		logic div_last;
	} sts_t;

endpackage

// File: hw/rtl/nnsf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module nnsf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: hw/rtl/nnsf_ctrl.sv
// Controller of the frame scaler: sequences load, map, read, output and divide steps.
// Depends on nnsf_pkg.
`timescale 1ns / 1ps

module nnsf_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic           func,
	output logic           busy,
	output logic           strobe,
	input  nnsf_pkg::sts_t sts,
	output nnsf_pkg::cmd_t cmd
);
	import nnsf_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOAD,
		S_MAP,
		S_ADDR,
		S_OUT,
		S_DIV,
		S_APPLY
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign busy = (state_q == S_MAP) || (state_q == S_ADDR) || (state_q == S_DIV) ||
		((state_q == S_OUT) && sts.need_div);
	assign accept = start && !busy;
	assign strobe = (state_q == S_OUT);

	always_comb begin
		cmd            = '0;
		cmd.capture    = accept;
		cmd.load       = (state_q == S_LOAD);
		cmd.map        = (state_q == S_MAP);
		cmd.addr       = (state_q == S_ADDR);
		cmd.apply_fast = (state_q == S_OUT) && !sts.need_div;
		cmd.div_start  = (state_q == S_OUT) && sts.need_div;
		cmd.div_step   = (state_q == S_DIV);
		cmd.apply_div  = (state_q == S_APPLY);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE, S_LOAD, S_APPLY: begin
				if (accept) begin
					state_d = func ? S_MAP : S_LOAD;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_MAP:  state_d = S_ADDR;
			S_ADDR: state_d = S_OUT;
			S_OUT: begin
				if (sts.need_div) begin
					state_d = S_DIV;
				end else if (accept) begin
					state_d = func ? S_MAP : S_LOAD;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_DIV:   state_d = sts.div_last ? S_APPLY : S_DIV;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef ASSERT_OFF
	a_emit_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && func |-> ##3 strobe)
		else $error("emit word without result strobe");

	a_strobe_single: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |=> !strobe)
		else $error("result strobe held two cycles");

	a_load_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && !func |=> !strobe && !busy)
		else $error("load word stalled or produced a result");
`endif

endmodule

// File: hw/rtl/nnsf_dp.sv
// Datapath of the frame scaler: size clamps, counters, accumulators, divider, frame store.
// Depends on nnsf_pkg and nnsf_ram.
`timescale 1ns / 1ps

module nnsf_dp #(
	parameter int MAX_SRC_WIDTH  = nnsf_pkg::MAX_SRC_WIDTH_DEF,
	parameter int MAX_SRC_HEIGHT = nnsf_pkg::MAX_SRC_HEIGHT_DEF,
	parameter int MAX_DST_DIM    = nnsf_pkg::MAX_DST_DIM_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  nnsf_pkg::cfg_t               cfg,
	input  nnsf_pkg::cmd_t               cmd,
	output nnsf_pkg::sts_t               sts,
	input  logic [nnsf_pkg::PIXEL_W-1:0] pixel,
	output logic [nnsf_pkg::PIXEL_W-1:0] out_pixel,
	output logic                         end_of_row,
	output logic                         end_of_frame
);
	import nnsf_pkg::*;

	localparam int SWW   = $clog2(MAX_SRC_WIDTH + 1);
	localparam int SHW   = $clog2(MAX_SRC_HEIGHT + 1);
	localparam int DDW   = $clog2(MAX_DST_DIM + 1);
	localparam int DCW   = $clog2(MAX_DST_DIM);
	localparam int PW    = (SWW > SHW) ? SWW : SHW;
	localparam int DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int FW    = $clog2(DEPTH + 1);
	localparam int TW    = $clog2(MAX_DST_DIM + MAX_SRC_WIDTH + MAX_SRC_HEIGHT);
	localparam int XW    = ((TW > DDW) ? TW : DDW) + 2;
	localparam int SUMW  = ((TW > PW) ? TW : PW) + 1;
	localparam int CNTW  = $clog2(TW + 1);

	// clamped sizes
	logic [SWW-1:0] sw;
	logic [SHW-1:0] sh;
	logic [DDW-1:0] dw;
	logic [DDW-1:0] dh;

	always_comb begin
		if (cfg.src_width == '0) begin
			sw = SWW'(1);
		end else if (32'(cfg.src_width) > 32'(MAX_SRC_WIDTH)) begin
			sw = SWW'(MAX_SRC_WIDTH);
		end else begin
			sw = SWW'(cfg.src_width);
		end
		if (cfg.src_height == '0) begin
			sh = SHW'(1);
		end else if (32'(cfg.src_height) > 32'(MAX_SRC_HEIGHT)) begin
			sh = SHW'(MAX_SRC_HEIGHT);
		end else begin
			sh = SHW'(cfg.src_height);
		end
		if (cfg.dst_width == '0) begin
			dw = DDW'(1);
		end else if (32'(cfg.dst_width) > 32'(MAX_DST_DIM)) begin
			dw = DDW'(MAX_DST_DIM);
		end else begin
			dw = DDW'(cfg.dst_width);
		end
		if (cfg.dst_height == '0) begin
			dh = DDW'(1);
		end else if (32'(cfg.dst_height) > 32'(MAX_DST_DIM)) begin
			dh = DDW'(MAX_DST_DIM);
		end else begin
			dh = DDW'(cfg.dst_height);
		end
	end

	// frame size, registered off the size registers
	logic [FW-1:0] frame_prod;
	logic [FW-1:0] frame_q;

	assign frame_prod = FW'(sw) * FW'(sh);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q <= '0;
		end else begin
			frame_q <= frame_prod;
		end
	end

	// state
	logic [AW-1:0]      load_index_q;
	logic [DCW-1:0]     dest_col_q;
	logic [DCW-1:0]     dest_row_q;
	logic [SWW-1:0]     src_col_q;
	logic [SHW-1:0]     src_row_q;
	logic [DCW-1:0]     col_rem_q;
	logic [DCW-1:0]     row_rem_q;
	logic [PIXEL_W-1:0] pix_q;

	// load pointer
	logic [AW-1:0] load_addr;
	logic [FW-1:0] load_next;

	assign load_addr = (FW'(load_index_q) < frame_q) ? load_index_q : '0;
	assign load_next = FW'(load_addr) + FW'(1);

	// map stage
	logic [SWW-1:0] col_sat;
	logic [SWW-1:0] col_map;
	logic [SHW-1:0] row_sat;
	logic [SHW-1:0] row_map;
	logic           eor;
	logic           eof;
	logic [TW-1:0]  total;

	logic [SWW-1:0] col_s1;
	logic [SHW-1:0] row_s1;
	logic           eor_s1;
	logic           eof_s1;
	logic [TW-1:0]  total_s1;
	logic [DDW-1:0] den_s1;

	always_comb begin
		col_sat = (src_col_q < sw) ? src_col_q : sw - SWW'(1);
		row_sat = (src_row_q < sh) ? src_row_q : sh - SHW'(1);
		col_map = cfg.flip_x ? (sw - SWW'(1) - col_sat) : col_sat;
		row_map = cfg.flip_y ? (sh - SHW'(1) - row_sat) : row_sat;
		eor     = DDW'(dest_col_q) >= (dw - DDW'(1));
		eof     = eor && (DDW'(dest_row_q) >= (dh - DDW'(1)));
		// the row accumulator steps at the end of a row, the column one otherwise
		if (eor) begin
			total = TW'(row_rem_q) + TW'(sh);
		end else begin
			total = TW'(col_rem_q) + TW'(sw);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.map) begin
			col_s1   <= col_map;
			row_s1   <= row_map;
			eor_s1   <= eor;
			eof_s1   <= eof;
			total_s1 <= total;
			den_s1   <= eor ? dh : dw;
		end
	end

	// read address and quick quotient check
	logic [AW-1:0]  raddr;
	logic [XW-1:0]  tx;
	logic [XW-1:0]  d1;
	logic [XW-1:0]  d2;
	logic [XW-1:0]  tx_sub;
	logic           ge1;
	logic           ge2;

	assign raddr    = (AW'(row_s1) * AW'(sw)) + AW'(col_s1);
	assign tx       = XW'(total_s1);
	assign d1       = XW'(den_s1);
	assign d2       = d1 << 1;
	assign ge1      = tx >= d1;
	assign ge2      = tx >= d2;
	assign tx_sub   = ge1 ? (tx - d1) : tx;

	// quotient and remainder, shared by the quick path and the divider
	logic [TW-1:0]   quo_q;
	logic [DDW:0]    res_r_q;
	logic [TW-1:0]   div_t_q;
	logic [CNTW-1:0] div_cnt_q;
	logic            need_div_q;
	logic [DDW:0]    r_sh;
	logic            r_ge;

	assign r_sh = {res_r_q[DDW-1:0], div_t_q[TW-1]};
	assign r_ge = r_sh >= {1'b0, den_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			need_div_q <= 1'b0;
			div_cnt_q  <= '0;
		end else begin
			if (cmd.addr) begin
				need_div_q <= ge2 && !eof_s1;
			end else if (cmd.div_start) begin
				need_div_q <= 1'b0;
			end
			if (cmd.div_start) begin
				div_cnt_q <= CNTW'(TW);
			end else if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q - CNTW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.addr) begin
			quo_q   <= ge1 ? TW'(1) : '0;
			res_r_q <= tx_sub[DDW:0];
		end else if (cmd.div_start) begin
			quo_q   <= '0;
			res_r_q <= '0;
			div_t_q <= total_s1;
		end else if (cmd.div_step) begin
			quo_q   <= {quo_q[TW-2:0], r_ge};
			res_r_q <= r_ge ? (r_sh - {1'b0, den_s1}) : r_sh;
			div_t_q <= div_t_q << 1;
		end
	end

	assign sts.need_div = need_div_q;
	assign sts.div_last = (div_cnt_q == CNTW'(1));

	// counter commit
	logic           apply;
	logic [SUMW-1:0] col_sum;
	logic [SUMW-1:0] row_sum;
	logic [SWW-1:0]  col_new;
	logic [SHW-1:0]  row_new;

	assign apply   = cmd.apply_fast || cmd.apply_div;
	assign col_sum = SUMW'(src_col_q) + SUMW'(quo_q);
	assign row_sum = SUMW'(src_row_q) + SUMW'(quo_q);
	assign col_new = (col_sum > SUMW'(sw)) ? sw : col_sum[SWW-1:0];
	assign row_new = (row_sum > SUMW'(sh)) ? sh : row_sum[SHW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_index_q <= '0;
			dest_col_q   <= '0;
			dest_row_q   <= '0;
			src_col_q    <= '0;
			src_row_q    <= '0;
			col_rem_q    <= '0;
			row_rem_q    <= '0;
		end else begin
			if (cmd.load) begin
				load_index_q <= (load_next >= frame_q) ? '0 : load_next[AW-1:0];
			end
			if (apply) begin
				if (!eor_s1) begin
					dest_col_q <= dest_col_q + DCW'(1);
					src_col_q  <= col_new;
					col_rem_q  <= res_r_q[DCW-1:0];
				end else begin
					dest_col_q <= '0;
					src_col_q  <= '0;
					col_rem_q  <= '0;
					if (eof_s1) begin
						dest_row_q <= '0;
						src_row_q  <= '0;
						row_rem_q  <= '0;
					end else begin
						dest_row_q <= dest_row_q + DCW'(1);
						src_row_q  <= row_new;
						row_rem_q  <= res_r_q[DCW-1:0];
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			pix_q <= pixel;
		end
	end

	nnsf_ram #(
		.WIDTH (PIXEL_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (cmd.load),
		.waddr (load_addr),
		.wdata (pix_q),
		.re    (cmd.addr),
		.raddr (raddr),
		.rdata (out_pixel)
	);

	assign end_of_row   = eor_s1;
	assign end_of_frame = eof_s1;

`ifndef ASSERT_OFF
	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> div_cnt_q != '0)
		else $error("divider stepped past its last bit");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.apply_div || (cmd.apply_fast && !eof_s1) |-> res_r_q < {1'b0, den_s1})
		else $error("accumulator remainder not below divisor");
`endif

endmodule

// File: hw/rtl/nearest_neighbor_scaler_flip.sv
// Nearest-neighbor frame scaler with mirroring. A load word is written to the store
// and does not stall. An emit word runs the map, read and output states and strobes its
// result in the output state; when the accumulator steps by more than one source pixel,
// the bit-serial divider runs before the counters commit, with busy holding off words.
// Async reset clears counters and loads register defaults; the frame store is not cleared.
// The receiver cannot stall: each result is on the ports for exactly one cycle.
`timescale 1ns / 1ps

module nearest_neighbor_scaler_flip #(
	parameter int MAX_SRC_WIDTH  = nnsf_pkg::MAX_SRC_WIDTH_DEF,
	parameter int MAX_SRC_HEIGHT = nnsf_pkg::MAX_SRC_HEIGHT_DEF,
	parameter int MAX_DST_DIM    = nnsf_pkg::MAX_DST_DIM_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// item channel
	input  logic                            start,
	output logic                            busy,
	input  logic                            func,
	input  logic [nnsf_pkg::PIXEL_W-1:0]    pixel,
	// result channel
	output logic                            strobe,
	output logic [nnsf_pkg::PIXEL_W-1:0]    out_pixel,
	output logic                            end_of_row,
	output logic                            end_of_frame,
	// register write channel
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [nnsf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [nnsf_pkg::CFG_DATA_W-1:0] cfg_data
);
	import nnsf_pkg::*;

	cfg_t cfg_q;
	cmd_t cmd;
	sts_t sts;

	// Registers take a word every cycle; writes to unused indexes drop silently.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.src_width  <= SRC_WIDTH_RST;
			cfg_q.src_height <= SRC_HEIGHT_RST;
			cfg_q.dst_width  <= DST_WIDTH_RST;
			cfg_q.dst_height <= DST_HEIGHT_RST;
			cfg_q.flip_x     <= 1'b0;
			cfg_q.flip_y     <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_SRC_WIDTH:  cfg_q.src_width  <= cfg_data[SRC_WIDTH_W-1:0];
				REG_SRC_HEIGHT: cfg_q.src_height <= cfg_data[SRC_HEIGHT_W-1:0];
				REG_DST_WIDTH:  cfg_q.dst_width  <= cfg_data[DST_DIM_W-1:0];
				REG_DST_HEIGHT: cfg_q.dst_height <= cfg_data[DST_DIM_W-1:0];
				REG_FLIP_X:     cfg_q.flip_x     <= cfg_data[0];
				REG_FLIP_Y:     cfg_q.flip_y     <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// Sequencer: decides which datapath step runs each cycle and when a word is taken.
	nnsf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.func   (func),
		.busy   (busy),
		.strobe (strobe),
		.sts    (sts),
		.cmd    (cmd)
	);

	// Datapath: size clamps, raster counters, remainder accumulators, divider and store.
	nnsf_dp #(
		.MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
		.MAX_SRC_HEIGHT (MAX_SRC_HEIGHT),
		.MAX_DST_DIM    (MAX_DST_DIM)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.cmd          (cmd),
		.sts          (sts),
		.pixel        (pixel),
		.out_pixel    (out_pixel),
		.end_of_row   (end_of_row),
		.end_of_frame (end_of_frame)
	);

endmodule
